[sv/bcc_pkg.sv]
// Shared types and constants for the button click classifier.
package bcc_pkg;

    localparam int CFG_W  = 16;
    localparam int MODE_W = 3;
    localparam int KIND_W = 2;
    localparam int IDX_W  = 2;

    localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DEBOUNCE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_HELD     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_GAP      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_WAIT_REL = 3'd4;
    localparam logic [MODE_W-1:0] MODE_LOCKOUT  = 3'd5;

    localparam logic [KIND_W-1:0] EV_SINGLE = 2'd0;
    localparam logic [KIND_W-1:0] EV_DOUBLE = 2'd1;
    localparam logic [KIND_W-1:0] EV_LONG   = 2'd2;

    localparam logic [IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [IDX_W-1:0] REG_LONG     = 2'd1;
    localparam logic [IDX_W-1:0] REG_GAP      = 2'd2;
    localparam logic [IDX_W-1:0] REG_LOCKOUT  = 2'd3;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [CFG_W-1:0] LONG_RST     = 16'd1000;
    localparam logic [CFG_W-1:0] GAP_RST      = 16'd370;
    localparam logic [CFG_W-1:0] LOCKOUT_RST  = 16'd100;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] long_press_ticks;
        logic [CFG_W-1:0] double_gap_ticks;
        logic [CFG_W-1:0] lockout_ticks;
    } bcc_cfg_t;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
    } bcc_evt_t;

endpackage

[sv/bcc_step.sv]
// Next-state and event logic for one tick of the click classifier.
module bcc_step
    import bcc_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  bcc_cfg_t              cfg,
    input  logic                  pin_level,
    input  logic                  prev_level,
    input  logic [MODE_W-1:0]     mode,
    input  logic [TIMER_BITS-1:0] tick_count,
    input  logic [TIMER_BITS-1:0] gap_count,
    input  logic                  second_press,
    output logic [MODE_W-1:0]     mode_next,
    output logic [TIMER_BITS-1:0] tick_next,
    output logic [TIMER_BITS-1:0] gap_next,
    output logic                  second_next,
    output bcc_evt_t              evt
);

    localparam int LW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [TIMER_BITS-1:0] CNT_MAX = {TIMER_BITS{1'b1}};

    function automatic logic [TIMER_BITS-1:0] cnt_inc(input logic [TIMER_BITS-1:0] c);
        return (c == CNT_MAX) ? c : c + TIMER_BITS'(1);
    endfunction

    // counter reached limit, with the limit clamped to the counter range
    function automatic logic reached(input logic [TIMER_BITS-1:0] c,
                                     input logic [CFG_W-1:0] v);
        logic [LW-1:0] cx;
        logic [LW-1:0] vx;
        logic [LW-1:0] mx;
        cx = LW'(c);
        vx = LW'(v);
        mx = LW'(CNT_MAX);
        return (vx >= mx) ? (c == CNT_MAX) : (cx >= vx);
    endfunction

    logic fall;
    logic rise;

    assign fall = prev_level & ~pin_level;
    assign rise = ~prev_level & pin_level;

    always_comb begin
        mode_next   = mode;
        tick_next   = tick_count;
        gap_next    = gap_count;
        second_next = second_press;
        evt.valid   = 1'b0;
        evt.kind    = EV_SINGLE;
        case (mode)
            MODE_IDLE: begin
                if (fall) begin
                    mode_next   = MODE_DEBOUNCE;
                    tick_next   = '0;
                    second_next = 1'b0;
                    if (cfg.debounce_ticks == '0) begin
                        mode_next = MODE_HELD;
                    end
                end
            end
            MODE_DEBOUNCE: begin
                tick_next = cnt_inc(tick_count);
                if (second_press) begin
                    gap_next = cnt_inc(gap_count);
                end
                if (reached(tick_next, cfg.debounce_ticks)) begin
                    second_next = 1'b0;
                    if (!pin_level) begin
                        if (second_press) begin
                            mode_next = MODE_WAIT_REL;
                            evt.valid = 1'b1;
                            evt.kind  = EV_DOUBLE;
                        end else begin
                            mode_next = MODE_HELD;
                            tick_next = '0;
                        end
                    end else begin
                        mode_next = second_press ? MODE_GAP : MODE_IDLE;
                    end
                end
                if (second_press && !evt.valid &&
                    (mode_next == MODE_DEBOUNCE || mode_next == MODE_GAP) &&
                    reached(gap_next, cfg.double_gap_ticks)) begin
                    second_next = 1'b0;
                    evt.valid   = 1'b1;
                    evt.kind    = EV_SINGLE;
                    tick_next   = '0;
                    mode_next   = (cfg.lockout_ticks == '0) ? MODE_IDLE : MODE_LOCKOUT;
                end
            end
            MODE_HELD: begin
                tick_next = cnt_inc(tick_count);
                if (rise) begin
                    mode_next = MODE_GAP;
                    gap_next  = '0;
                end else if (reached(tick_next, cfg.long_press_ticks)) begin
                    mode_next = MODE_WAIT_REL;
                    evt.valid = 1'b1;
                    evt.kind  = EV_LONG;
                end
            end
            MODE_GAP: begin
                gap_next = cnt_inc(gap_count);
                if (reached(gap_next, cfg.double_gap_ticks)) begin
                    evt.valid = 1'b1;
                    evt.kind  = EV_SINGLE;
                    tick_next = '0;
                    mode_next = (cfg.lockout_ticks == '0) ? MODE_IDLE : MODE_LOCKOUT;
                end else if (fall) begin
                    mode_next   = MODE_DEBOUNCE;
                    tick_next   = '0;
                    second_next = 1'b1;
                    if (cfg.debounce_ticks == '0) begin
                        second_next = 1'b0;
                        mode_next   = MODE_WAIT_REL;
                        evt.valid   = 1'b1;
                        evt.kind    = EV_DOUBLE;
                    end
                end
            end
            MODE_WAIT_REL: begin
                if (rise) begin
                    tick_next = '0;
                    mode_next = (cfg.lockout_ticks == '0) ? MODE_IDLE : MODE_LOCKOUT;
                end
            end
            MODE_LOCKOUT: begin
                tick_next = cnt_inc(tick_count);
                if (reached(tick_next, cfg.lockout_ticks)) begin
                    mode_next = MODE_IDLE;
                end
            end
            default: begin
                mode_next   = MODE_IDLE;
                second_next = 1'b0;
            end
        endcase
    end

endmodule

[sv/button_click_classifier.sv]
// A result request is registered and appears on m_ in the cycle after the tick that causes it.
// One tick per cycle while s_tready is high; the mode and counter registers update on each accepted tick.
// s_tready drops only while a finished result waits on a stalled m_ side.
// Reset (aresetn low, synchronous): mode idle, counters zero, pin history released,
// registers back to their defaults, no result pending.
module button_click_classifier
    import bcc_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [0] pin_level, [7:1] zero
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata    // [1:0] event_kind, [7:2] zero
);

    bcc_cfg_t              cfg_reg;
    logic [MODE_W-1:0]     mode_reg;
    logic [TIMER_BITS-1:0] tick_reg;
    logic [TIMER_BITS-1:0] gap_reg;
    logic                  second_reg;
    logic                  prev_reg;
    logic                  m_valid_reg;
    logic [KIND_W-1:0]     m_kind_reg;

    logic [MODE_W-1:0]     mode_next;
    logic [TIMER_BITS-1:0] tick_next;
    logic [TIMER_BITS-1:0] gap_next;
    logic                  second_next;
    bcc_evt_t              evt;
    logic                  s_fire;

    assign s_tready = ~m_valid_reg | m_tready;
    assign s_fire   = s_tvalid & s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(8 - KIND_W){1'b0}}, m_kind_reg};

    bcc_step #(
        .TIMER_BITS(TIMER_BITS)
    ) u_step (
        .cfg         (cfg_reg),
        .pin_level   (s_tdata[0]),
        .prev_level  (prev_reg),
        .mode        (mode_reg),
        .tick_count  (tick_reg),
        .gap_count   (gap_reg),
        .second_press(second_reg),
        .mode_next   (mode_next),
        .tick_next   (tick_next),
        .gap_next    (gap_next),
        .second_next (second_next),
        .evt         (evt)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks   <= DEBOUNCE_RST;
            cfg_reg.long_press_ticks <= LONG_RST;
            cfg_reg.double_gap_ticks <= GAP_RST;
            cfg_reg.lockout_ticks    <= LOCKOUT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DEBOUNCE: cfg_reg.debounce_ticks   <= cfg_wdata;
                REG_LONG:     cfg_reg.long_press_ticks <= cfg_wdata;
                REG_GAP:      cfg_reg.double_gap_ticks <= cfg_wdata;
                REG_LOCKOUT:  cfg_reg.lockout_ticks    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            tick_reg   <= '0;
            gap_reg    <= '0;
            second_reg <= 1'b0;
            prev_reg   <= 1'b1;
        end else if (s_fire) begin
            mode_reg   <= mode_next;
            tick_reg   <= tick_next;
            gap_reg    <= gap_next;
            second_reg <= second_next;
            prev_reg   <= s_tdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire && evt.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && evt.valid) begin
            m_kind_reg <= evt.kind;
        end
    end

`ifndef ASSERT_OFF
    a_second_only_in_debounce: assert property (@(posedge aclk) disable iff (!aresetn)
        second_reg |-> mode_reg == MODE_DEBOUNCE)
        else $error("second press flag outside debounce");

    a_double_source: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && evt.valid && evt.kind == EV_DOUBLE |-> second_reg || mode_reg == MODE_GAP)
        else $error("double click without a pending second press");

    a_long_source: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && evt.valid && evt.kind == EV_LONG |-> mode_reg == MODE_HELD)
        else $error("long press outside held mode");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && evt.valid |=> m_tvalid && m_kind_reg != 2'd3)
        else $error("result request lost or invalid kind");
`endif

endmodule

[sim/button_click_classifier_test.sv]
// Self-checking testbench for the button click classifier: random tick streams, class scoreboard.
module button_click_classifier_test;
    import bcc_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int STALL_CYCLES = 300;
    localparam int PHASES       = 8;
    localparam int PHASE_TICKS  = 85;
    localparam bit [0:19] TAP_SEQ = 20'b1011_1010_1000_0110_0111;

    class click_scoreboard;
        logic [CFG_W-1:0]  debounce_lim;
        logic [CFG_W-1:0]  long_lim;
        logic [CFG_W-1:0]  gap_lim;
        logic [CFG_W-1:0]  lockout_lim;
        logic [MODE_W-1:0] mode;
        logic [CFG_W-1:0]  tick_count;
        logic [CFG_W-1:0]  gap_count;
        bit                prev_level;
        bit                second_press;
        logic [KIND_W-1:0] expected_kinds[$];
        int                mismatches;

        function new();
            debounce_lim = DEBOUNCE_RST;
            long_lim     = LONG_RST;
            gap_lim      = GAP_RST;
            lockout_lim  = LOCKOUT_RST;
            mode         = MODE_IDLE;
            tick_count   = '0;
            gap_count    = '0;
            prev_level   = 1'b1;
            second_press = 1'b0;
            mismatches   = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_DEBOUNCE: debounce_lim = val;
                REG_LONG:     long_lim     = val;
                REG_GAP:      gap_lim      = val;
                REG_LOCKOUT:  lockout_lim  = val;
                default: ;
            endcase
        endfunction

        function logic [CFG_W-1:0] bump(logic [CFG_W-1:0] c);
            return (c == {CFG_W{1'b1}}) ? c : c + 1'b1;
        endfunction

        function void enter_lockout();
            mode = MODE_LOCKOUT;
            tick_count = '0;
            if (lockout_lim == 0) mode = MODE_IDLE;
        endfunction

        function bit resolve(bit pin, output logic [KIND_W-1:0] kind);
            kind = EV_SINGLE;
            if (!pin) begin
                if (second_press) begin
                    second_press = 1'b0;
                    mode = MODE_WAIT_REL;
                    kind = EV_DOUBLE;
                    return 1'b1;
                end
                mode = MODE_HELD;
                tick_count = '0;
                return 1'b0;
            end
            if (second_press) begin
                second_press = 1'b0;
                mode = MODE_GAP;
            end else begin
                mode = MODE_IDLE;
            end
            return 1'b0;
        endfunction

        function bit start_debounce(bit second, bit pin, output logic [KIND_W-1:0] kind);
            kind = EV_SINGLE;
            mode = MODE_DEBOUNCE;
            tick_count = '0;
            second_press = second;
            if (debounce_lim == 0) return resolve(pin, kind);
            return 1'b0;
        endfunction

        // Advance one tick; return 1 when the tick reports a click.
        function bit classify_tick(bit pin, output logic [KIND_W-1:0] kind);
            bit fall;
            bit rise;
            bit hit;
            bit was_second;
            fall = prev_level && !pin;
            rise = !prev_level && pin;
            hit  = 1'b0;
            kind = EV_SINGLE;
            case (mode)
                MODE_IDLE: begin
                    if (fall) hit = start_debounce(1'b0, pin, kind);
                end
                MODE_DEBOUNCE: begin
                    was_second = second_press;
                    tick_count = bump(tick_count);
                    if (was_second) gap_count = bump(gap_count);
                    if (tick_count >= debounce_lim) hit = resolve(pin, kind);
                    if (was_second && !hit && (mode == MODE_DEBOUNCE || mode == MODE_GAP)
                            && gap_count >= gap_lim) begin
                        second_press = 1'b0;
                        kind = EV_SINGLE;
                        hit = 1'b1;
                        enter_lockout();
                    end
                end
                MODE_HELD: begin
                    tick_count = bump(tick_count);
                    if (rise) begin
                        mode = MODE_GAP;
                        gap_count = '0;
                    end else if (tick_count >= long_lim) begin
                        kind = EV_LONG;
                        hit = 1'b1;
                        mode = MODE_WAIT_REL;
                    end
                end
                MODE_GAP: begin
                    gap_count = bump(gap_count);
                    if (gap_count >= gap_lim) begin
                        kind = EV_SINGLE;
                        hit = 1'b1;
                        enter_lockout();
                    end else if (fall) begin
                        hit = start_debounce(1'b1, pin, kind);
                    end
                end
                MODE_WAIT_REL: begin
                    if (rise) enter_lockout();
                end
                MODE_LOCKOUT: begin
                    tick_count = bump(tick_count);
                    if (tick_count >= lockout_lim) mode = MODE_IDLE;
                end
                default: begin
                    mode = MODE_IDLE;
                    second_press = 1'b0;
                end
            endcase
            prev_level = pin;
            return hit;
        endfunction

        function void note_tick(bit pin);
            logic [KIND_W-1:0] kind;
            if (classify_tick(pin, kind)) expected_kinds.push_back(kind);
        endfunction

        function void check_event(logic [KIND_W-1:0] kind);
            logic [KIND_W-1:0] want;
            if (expected_kinds.size() == 0) begin
                $display("%0t: unexpected event, expected none, actual %0d", $time, kind);
                mismatches++;
                return;
            end
            want = expected_kinds.pop_front();
            if (kind !== want) begin
                $display("%0t: event_kind mismatch, expected %0d, actual %0d", $time, want, kind);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_kinds.size();
        endfunction
    endclass

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_wdata;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;   // [0] pin_level, [7:1] zero
    logic             m_tvalid;
    logic             m_tready;
    logic [7:0]       m_tdata;   // [1:0] event_kind, [7:2] zero

    click_scoreboard sb;
    bit              idle_on;
    bit              stall_req;
    int              cycles;
    int              cur_dbc;
    int              cur_long;
    int              cur_gap;

    button_click_classifier u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_event(m_tdata[KIND_W-1:0]);
    end

    initial begin : receiver
        int wait_n;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_req) begin
                m_tready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge aclk);
                stall_req = 1'b0;
            end
            wait_n = idle_on ? $urandom_range(0, 12) : 0;
            if (wait_n > 0) begin
                m_tready <= 1'b0;
                repeat (wait_n) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid && !stall_req);
        end
    end

    task automatic send_tick(input bit pin);
        int gap;
        gap = idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, pin};
        do @(posedge aclk); while (!s_tready);
        sb.note_tick(pin);
        @(negedge aclk);
    endtask

    // Hold the input until every expected request has drained, then settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_config(input int dbc, input int lng, input int gap, input int lock);
        logic [IDX_W-1:0] idx[4];
        int               val[4];
        idx = '{REG_DEBOUNCE, REG_LONG, REG_GAP, REG_LOCKOUT};
        val = '{dbc, lng, gap, lock};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i][CFG_W-1:0];
            sb.set_reg(idx[i], val[i][CFG_W-1:0]);
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        cur_dbc  = dbc;
        cur_long = lng;
        cur_gap  = gap;
    endtask

    // Alternate pin levels in runs sized around the current windows.
    task automatic send_presses(input int count, input int stall_at);
        bit level;
        int len;
        int sent;
        level = 1'b1;
        sent  = 0;
        while (sent < count) begin
            level = !level;
            case ($urandom_range(0, 3))
                0:       len = $urandom_range(1, 2);
                1:       len = $urandom_range(1, cur_dbc + 3);
                2:       len = $urandom_range(1, cur_long + 4);
                default: len = $urandom_range(1, cur_gap + 4);
            endcase
            for (int k = 0; k < len && sent < count; k++) begin
                if (sent == stall_at) stall_req = 1'b1;
                send_tick(level);
                sent++;
            end
        end
    endtask

    initial begin
        sb        = new();
        cycles    = 0;
        idle_on   = 1'b1;
        stall_req = 1'b0;
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cur_dbc   = DEBOUNCE_RST;
        cur_long  = LONG_RST;
        cur_gap   = GAP_RST;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_tick(1'b1);
        repeat (4) send_tick(1'b0);
        drain();
        set_config(0, 3, 2, 0);
        for (int i = 0; i < 20; i++) send_tick(TAP_SEQ[i]);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            idle_on = (ph % 3 != 1);
            if (ph == 0) begin
                set_config(0, 1, 1, 0);
            end else begin
                set_config($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 4),
                           $urandom_range(1, 20),
                           $urandom_range(1, 12),
                           $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8));
            end
            if (ph == 4) begin
                idle_on = 1'b0;
                send_presses(PHASE_TICKS, 15);
            end else begin
                send_presses(PHASE_TICKS, -1);
            end
            drain();
        end

        idle_on = 1'b1;
        set_config(65535, 65535, 65535, 65535);
        send_presses(20, -1);
        drain();

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/bcc_pkg.sv
sv/bcc_step.sv
sv/button_click_classifier.sv
sim/button_click_classifier_test.sv
